>>> design/pds_pkg.sv
package pds_pkg;

    // Command codes carried on the cmd port; the eighth code is unused.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_EDIT       = 3'd4,
        CMD_INSERT     = 3'd5,
        CMD_REMOVE     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BOUND = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What every cell of the chain does; all cells share the same mode.
    typedef enum logic [1:0] {
        MODE_HOLD  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_SHR   = 2'd2,
        MODE_SHL   = 2'd3
    } mode_t;

    // Source of the returned value.
    typedef enum logic [1:0] {
        DSEL_ZERO = 2'd0,
        DSEL_NEG  = 2'd1,
        DSEL_READ = 2'd2
    } dsel_t;

    typedef struct packed {
        status_t status;
        dsel_t   dsel;
    } resp_t;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam logic [DATA_W-1:0] NEG_ONE = '1;

endpackage

>>> design/pds_cell.sv
module pds_cell
    import pds_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic                     clk,
    input  mode_t                    mode,
    input  logic [IDX_W-1:0]         idx,
    input  logic [IDX_W-1:0]         rd_idx,
    input  logic signed [DATA_W-1:0] data_in,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] rd_val
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     at_idx;
    logic                     past_idx;

    assign at_idx   = (MY_IDX == idx);
    assign past_idx = (MY_IDX > idx);

    always_comb
    begin
        value_next = value_reg;
        unique case (mode)
            MODE_WRITE:
            begin
                if (at_idx)
                begin
                    value_next = data_in;
                end
            end
            MODE_SHR:
            begin
                if (at_idx)
                begin
                    value_next = data_in;
                end
                else if (past_idx)
                begin
                    value_next = left_val;
                end
            end
            MODE_SHL:
            begin
                if (at_idx || past_idx)
                begin
                    value_next = right_val;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value  = value_reg;
    assign rd_val = (MY_IDX == rd_idx) ? value_reg : '0;

endmodule

>>> design/pds_ctrl.sv
module pds_ctrl
    import pds_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
)
(
    input  logic             fire,
    input  logic [2:0]       cmd,
    input  logic [POS_W-1:0] position,
    input  logic [CNT_W-1:0] count_cur,
    output mode_t            mode,
    output logic [IDX_W-1:0] idx,
    output logic [IDX_W-1:0] rd_idx,
    output resp_t            resp,
    output logic [CNT_W-1:0] count_next
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] cnt_m1;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] tail_idx;
    logic             pos_ok;
    logic             full;
    logic             empty;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_cur);
    assign pos_m1   = pos_ext - CMP_W'(1);
    assign cnt_m1   = cnt_ext - CMP_W'(1);
    assign pos_idx  = pos_m1[IDX_W-1:0];
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign tail_idx = cnt_ext[IDX_W-1:0];
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign full     = (count_cur == CNT_W'(DEPTH));
    assign empty    = (count_cur == '0);

    always_comb
    begin
        mode        = MODE_HOLD;
        idx         = '0;
        rd_idx      = '0;
        resp.status = ST_OK;
        resp.dsel   = DSEL_ZERO;
        count_next  = count_cur;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    resp.status = ST_FULL;
                end
                else
                begin
                    mode       = MODE_SHR;
                    count_next = count_cur + CNT_W'(1);
                end
            end
            CMD_PUSH_REAR:
            begin
                if (full)
                begin
                    resp.status = ST_FULL;
                end
                else
                begin
                    mode       = MODE_WRITE;
                    idx        = tail_idx;
                    count_next = count_cur + CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    resp.status = ST_EMPTY;
                    resp.dsel   = DSEL_NEG;
                end
                else
                begin
                    mode       = MODE_SHL;
                    resp.dsel  = DSEL_READ;
                    count_next = count_cur - CNT_W'(1);
                end
            end
            CMD_POP_REAR:
            begin
                if (empty)
                begin
                    resp.status = ST_EMPTY;
                    resp.dsel   = DSEL_NEG;
                end
                else
                begin
                    rd_idx     = last_idx;
                    resp.dsel  = DSEL_READ;
                    count_next = count_cur - CNT_W'(1);
                end
            end
            CMD_EDIT:
            begin
                if (!pos_ok)
                begin
                    resp.status = ST_BOUND;
                end
                else
                begin
                    mode = MODE_WRITE;
                    idx  = pos_idx;
                end
            end
            CMD_INSERT:
            begin
                if (!pos_ok)
                begin
                    resp.status = ST_BOUND;
                end
                else if (full)
                begin
                    resp.status = ST_FULL;
                end
                else
                begin
                    mode       = MODE_SHR;
                    idx        = pos_idx;
                    count_next = count_cur + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!pos_ok)
                begin
                    resp.status = ST_BOUND;
                    resp.dsel   = DSEL_NEG;
                end
                else
                begin
                    mode       = MODE_SHL;
                    idx        = pos_idx;
                    rd_idx     = pos_idx;
                    resp.dsel  = DSEL_READ;
                    count_next = count_cur - CNT_W'(1);
                end
            end
            default:
            begin
                mode = MODE_HOLD;
            end
        endcase
        if (!fire)
        begin
            mode       = MODE_HOLD;
            count_next = count_cur;
        end
    end

endmodule

>>> design/positional_deque_store.sv
// Positional deque store. Holds an ordered list of up to DEPTH signed 32-bit
// values in a chain of cells, one value per cell with the front in cell zero.
// A command is taken at any clock edge where start is high and busy is low;
// busy never rises, because each command completes in the cycle it is taken,
// so one transaction can be issued every clock cycle. In the cycle after
// the command, done pulses for one cycle with data_out, status and count; the
// receiver cannot stall, so it must capture them on that pulse. Push front,
// insert, pop front and remove move every cell behind the chosen position one
// place toward the rear or the front together; the value returned
// by a pop or remove is picked from the addressed cell through an AND-OR
// read bus across the chain. A refused or failed command leaves the list as
// it was and reports its reason in status.
module positional_deque_store
    import pds_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               cmd,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] data_in,
    output logic                     done,
    output logic signed [DATA_W-1:0] data_out,
    output logic [1:0]               status,
    output logic [COUNT_W-1:0]       count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic                     fire;
    mode_t                    mode;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         rd_idx;
    resp_t                    resp;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [EXT_W-1:0]         count_ext;
    logic signed [DATA_W-1:0] cell_val [DEPTH];
    logic signed [DATA_W-1:0] cell_rd  [DEPTH];
    logic signed [DATA_W-1:0] rd_bus;
    logic signed [DATA_W-1:0] dout_sel;
    logic                     done_reg;
    logic signed [DATA_W-1:0] data_out_reg;
    logic [1:0]               status_reg;
    logic [COUNT_W-1:0]       count_out_reg;

    // No command holds the block, so it is never busy.
    assign busy = 1'b0;
    assign fire = start && !busy;

    pds_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .fire       (fire),
        .cmd        (cmd),
        .position   (position),
        .count_cur  (count_reg),
        .mode       (mode),
        .idx        (idx),
        .rd_idx     (rd_idx),
        .resp       (resp),
        .count_next (count_next)
    );

    // The cell chain. Each cell sees its neighbors; the ends see zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        pds_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .mode      (mode),
            .idx       (idx),
            .rd_idx    (rd_idx),
            .data_in   (data_in),
            .left_val  (left_val),
            .right_val (right_val),
            .value     (cell_val[i]),
            .rd_val    (cell_rd[i])
        );
    end

    // Only the addressed cell drives a nonzero value onto the read bus.
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    always_comb
    begin
        case (resp.dsel)
            DSEL_NEG:  dout_sel = NEG_ONE;
            DSEL_READ: dout_sel = rd_bus;
            default:   dout_sel = '0;
        endcase
    end

    // The count port shows the entry count reduced to its field width.
    assign count_ext = EXT_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= fire;
        end
    end

    // Result payload registers; qualified by done, so no reset is needed.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_out_reg  <= dout_sel;
            status_reg    <= resp.status;
            count_out_reg <= count_ext[COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign data_out = data_out_reg;
    assign status   = status_reg;
    assign count    = count_out_reg;

endmodule
